// File: hw/rtl/tdse_pkg.sv
`timescale 1ns / 1ps
package tdse_pkg;
  localparam int MaxResiduals = 1024;
  localparam logic [15:0] DofReset = 16'd1280;
  localparam logic [7:0] IterLimitReset = 8'd50;
  localparam logic [31:0] MinStepReset = 32'd66;
  localparam logic [31:0] OneQ16 = 32'h0001_0000;
  localparam logic [1:0] CfgDof = 2'd0;
  localparam logic [1:0] CfgIterLimit = 2'd1;
  localparam logic [1:0] CfgMinStep = 2'd2;

  // word queued from the front to the back: a load or a start
  typedef struct packed {
    logic [31:0] residual;
    logic        last;
  } item_t;
endpackage

// File: hw/rtl/tdse_if.sv
`timescale 1ns / 1ps
interface tdse_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] residual;
  logic        last_residual;
  modport source (output valid, residual, last_residual, input ready);
  modport sink (input valid, residual, last_residual, output ready);
endinterface

interface tdse_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] scale_sigma;
  logic [7:0]  iterations_used;
  modport source (output valid, scale_sigma, iterations_used, input ready);
  modport sink (input valid, scale_sigma, iterations_used, output ready);
endinterface

interface tdse_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: hw/rtl/tdse_ram.sv
`timescale 1ns / 1ps
module tdse_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(Depth)-1:0] wr_addr,
  input  logic [Width-1:0]         wr_data,
  input  logic [$clog2(Depth)-1:0] rd_addr,
  output logic [Width-1:0]         rd_data
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end
endmodule

// File: hw/rtl/tdse_front.sv
`timescale 1ns / 1ps
// Front: accept words into a two-entry queue
module tdse_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  tdse_pkg::item_t in_item,
  output logic           q_valid,
  input  logic           q_ready,
  output tdse_pkg::item_t q_item
);
  tdse_pkg::item_t buf_r [2];
  logic rd_ptr_r, wr_ptr_r;
  logic [1:0] cnt_r;
  logic push, pop;

  assign in_ready = (cnt_r != 2'd2);
  assign q_valid = (cnt_r != 2'd0);
  assign q_item = buf_r[rd_ptr_r];
  assign push = in_valid && in_ready;
  assign pop = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) buf_r[wr_ptr_r] <= in_item;
    if (!rst_n) begin
      rd_ptr_r <= 1'b0;
      wr_ptr_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop) rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

// File: hw/rtl/tdse_back.sv
`timescale 1ns / 1ps
// Back: store residuals, then run the refinement sequencer
module tdse_back #(
  parameter int MaxResiduals = tdse_pkg::MaxResiduals
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  output logic            q_ready,
  input  tdse_pkg::item_t q_item,
  input  logic [15:0]     dof,
  input  logic [7:0]      iter_limit,
  input  logic [31:0]     min_step,
  output logic            res_valid,
  input  logic            res_ready,
  output logic [31:0]     res_sigma,
  output logic [7:0]      res_iters,
  output logic            busy
);
  localparam int AW = $clog2(MaxResiduals);
  localparam int CW = $clog2(MaxResiduals + 1);

  localparam logic [3:0] S_LOAD  = 4'd0;
  localparam logic [3:0] S_ITER  = 4'd1;
  localparam logic [3:0] S_RD    = 4'd2;
  localparam logic [3:0] S_QDIV  = 4'd3;
  localparam logic [3:0] S_QSQ   = 4'd4;
  localparam logic [3:0] S_MUL   = 4'd5;
  localparam logic [3:0] S_TDIV  = 4'd6;
  localparam logic [3:0] S_ACC   = 4'd7;
  localparam logic [3:0] S_MDIV  = 4'd8;
  localparam logic [3:0] S_SQRT  = 4'd9;
  localparam logic [3:0] S_NEXT  = 4'd10;
  localparam logic [3:0] S_OUT   = 4'd11;
  localparam logic [3:0] S_MUL2  = 4'd12;

  logic [3:0]   state_r;
  logic [CW-1:0] count_r, idx_r;
  logic [31:0]  sigma_r;
  logic [7:0]   iter_r;
  logic [63:0]  wsum_r;
  logic [31:0]  mag_r;
  logic [63:0]  q_r, m2_r, d_r;
  logic [127:0] num_r;
  logic [63:0]  quo_r;
  logic [64:0]  rem_r;
  logic [6:0]   bit_r;
  logic [63:0]  sq_rem_r, sq_res_r, sq_bit_r;
  logic [31:0]  ram_q;
  logic         ram_we;
  logic [AW-1:0] ram_wa, ram_ra;
  logic [31:0]  res_sigma_r;
  logic [7:0]   res_iters_r;
  logic         res_valid_r;
  logic [25:0]  scale;

  assign scale = {1'b0, {1'b0, dof} + 17'd256, 8'd0};
  assign q_ready = (state_r == S_LOAD);
  assign ram_we = q_valid && q_ready && (count_r < CW'(MaxResiduals));
  assign ram_wa = count_r[AW-1:0];
  assign ram_ra = idx_r[AW-1:0];
  assign res_valid = res_valid_r;
  assign res_sigma = res_sigma_r;
  assign res_iters = res_iters_r;
  assign busy = (state_r != S_LOAD) || res_valid_r || q_valid;

  tdse_ram #(.Width(32), .Depth(MaxResiduals)) u_ram (
    .clk(clk), .wr_en(ram_we), .wr_addr(ram_wa), .wr_data(q_item.residual),
    .rd_addr(ram_ra), .rd_data(ram_q)
  );

  logic [64:0] rem_sh;
  logic [31:0] new_sigma, step;
  logic [64:0] wsum_add;
  assign rem_sh = {rem_r[63:0], num_r[127]};
  assign wsum_add = {1'b0, wsum_r} + {1'b0, quo_r};
  assign new_sigma = sq_res_r[31:0];
  assign step = (new_sigma > sigma_r) ? new_sigma - sigma_r : sigma_r - new_sigma;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      count_r <= '0;
      idx_r <= '0;
      res_valid_r <= 1'b0;
      sigma_r <= tdse_pkg::OneQ16;
      iter_r <= '0;
    end else begin
      if (res_valid_r && res_ready) res_valid_r <= 1'b0;
      unique case (state_r)
        S_LOAD: begin
          // store one residual; a last word starts refinement
          if (q_valid && q_ready) begin
            if (ram_we) count_r <= count_r + 1'b1;
            if (q_item.last) begin
              sigma_r <= tdse_pkg::OneQ16;
              iter_r <= '0;
              state_r <= S_ITER;
            end
          end
        end
        S_ITER: begin
          idx_r <= '0;
          wsum_r <= '0;
          state_r <= S_RD;
        end
        S_RD: state_r <= S_QDIV;  // wait for registered read
        S_QDIV: begin
          // start q = mag<<16 / sigma
          mag_r <= ram_q[31] ? (~ram_q + 32'd1) : ram_q;
          num_r <= {16'd0, (ram_q[31] ? (~ram_q + 32'd1) : ram_q), 16'd0, 64'd0};
          d_r <= {32'd0, sigma_r};
          rem_r <= '0;
          bit_r <= 7'd64;
          state_r <= S_QSQ;
        end
        S_QSQ: begin
          // shared restoring divider, one bit a cycle
          if (bit_r != 0) begin
            num_r <= {num_r[126:0], 1'b0};
            quo_r <= {quo_r[62:0], (rem_sh >= {1'b0, d_r})};
            rem_r <= (rem_sh >= {1'b0, d_r}) ? rem_sh - {1'b0, d_r} : rem_sh;
            bit_r <= bit_r - 1'b1;
          end else begin
            q_r <= (quo_r > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : quo_r;
            m2_r <= 64'(mag_r) * 64'(mag_r);
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          d_r <= {8'd0, dof, 40'd0} >> 32;
          q_r <= (q_r[31:0] * q_r[31:0]) >> 16;
          state_r <= S_MUL2;
        end
        S_MUL2: begin
          d_r <= {40'd0, dof, 8'd0} + q_r;
          num_r <= {64'd0, 64'(m2_r[63:32]) * 64'(scale)} << 32;
          q_r <= 64'(m2_r[31:0]) * 64'(scale);
          state_r <= S_TDIV;
          bit_r <= 7'd0;
        end
        S_TDIV: begin
          if (bit_r == 0 && state_r == S_TDIV && rem_r != 65'h1_FFFF_FFFF_FFFF_FFFF) begin
            num_r <= num_r + 128'(q_r);
            rem_r <= 65'h1_FFFF_FFFF_FFFF_FFFF;
          end else if (rem_r == 65'h1_FFFF_FFFF_FFFF_FFFF) begin
            // term divide setup: zero for a zero d, saturating on overflow
            if (d_r == 0) begin
              quo_r <= '0;
              state_r <= S_ACC;
            end else if (num_r[127:64] >= d_r) begin
              quo_r <= '1;
              state_r <= S_ACC;
            end else begin
              rem_r <= {1'b0, num_r[127:64]};
              num_r <= {num_r[63:0], 64'd0};
              bit_r <= 7'd64;
              state_r <= S_ACC;
            end
          end
        end
        S_ACC: begin
          if (bit_r != 0) begin
            num_r <= {num_r[126:0], 1'b0};
            quo_r <= {quo_r[62:0], (rem_sh >= {1'b0, d_r})};
            rem_r <= (rem_sh >= {1'b0, d_r}) ? rem_sh - {1'b0, d_r} : rem_sh;
            bit_r <= bit_r - 1'b1;
          end else begin
            wsum_r <= wsum_add[64] ? '1 : wsum_add[63:0];
            rem_r <= '0;
            if (idx_r + 1'b1 >= count_r) begin
              // mean = wsum / count
              state_r <= S_MDIV;
              num_r <= {(wsum_add[64] ? 64'hFFFF_FFFF_FFFF_FFFF : wsum_add[63:0]), 64'd0};
              d_r <= 64'(count_r);
              bit_r <= 7'd64;
            end else begin
              idx_r <= idx_r + 1'b1;
              state_r <= S_RD;
            end
          end
        end
        S_MDIV: begin
          if (bit_r != 0) begin
            num_r <= {num_r[126:0], 1'b0};
            quo_r <= {quo_r[62:0], (rem_sh >= {1'b0, d_r})};
            rem_r <= (rem_sh >= {1'b0, d_r}) ? rem_sh - {1'b0, d_r} : rem_sh;
            bit_r <= bit_r - 1'b1;
          end else begin
            sq_rem_r <= quo_r;
            sq_res_r <= '0;
            sq_bit_r <= 64'h4000_0000_0000_0000;
            state_r <= S_SQRT;
          end
        end
        S_SQRT: begin
          // integer square root, one result bit a cycle
          if (sq_bit_r != 0) begin
            if (sq_rem_r >= sq_res_r + sq_bit_r) begin
              sq_rem_r <= sq_rem_r - (sq_res_r + sq_bit_r);
              sq_res_r <= (sq_res_r >> 1) + sq_bit_r;
            end else begin
              sq_res_r <= sq_res_r >> 1;
            end
            sq_bit_r <= sq_bit_r >> 2;
          end else begin
            state_r <= S_NEXT;
          end
        end
        S_NEXT: begin
          sigma_r <= new_sigma;
          iter_r <= iter_r + 8'd1;
          if (new_sigma == 0 || iter_r + 8'd1 >= iter_limit || step <= min_step)
            state_r <= S_OUT;
          else
            state_r <= S_ITER;
        end
        S_OUT: begin
          if (!res_valid_r) begin
            res_valid_r <= 1'b1;
            res_sigma_r <= sigma_r;
            res_iters_r <= iter_r;
            count_r <= '0;
            state_r <= S_LOAD;
          end
        end
        default: state_r <= S_LOAD;
      endcase
      // zero limit or empty store: skip refinement
      if (state_r == S_LOAD && q_valid && q_ready && q_item.last && iter_limit == 0) begin
        state_r <= S_OUT;
      end
      if (state_r == S_ITER && count_r == 0) begin
        sq_res_r <= '0;
        state_r <= S_NEXT;
      end
    end
  end
endmodule

// File: hw/rtl/t_distribution_scale_estimator.sv
`timescale 1ns / 1ps
// Student-t scale estimator.
// in_ channel: words of signed Q16.16 residual plus last_residual flag.
// Words pass a short queue into a residual memory, one per cycle when idle.
// A word with last_residual set starts refinement: sigma starts at 1.0 and
// each iteration walks the stored residuals with two 64-bit bit-serial divides
// per residual (one when the term saturates or its divisor is zero), then
// divides for the mean and takes a square root. Input stalls during
// refinement once the queue fills.
// out_ channel: one word (scale_sigma, iterations_used) per vector; it is held
// in an output register until taken, and the next vector loads behind it
// while it waits.
// cfg_ channel: index 0 degrees of freedom, 1 iteration limit, 2 minimum step;
// write only while idle. Reset (rst_n low, synchronous) empties the vector and
// restores register defaults; the memory needs no clearing pass.
module t_distribution_scale_estimator #(
  parameter int MaxResiduals = tdse_pkg::MaxResiduals
) (
  input  logic clk,
  input  logic rst_n,
  tdse_in_if.sink    in_ch,
  tdse_out_if.source out_ch,
  tdse_cfg_if.sink   cfg_ch
);
  logic [15:0] dof_r;
  logic [7:0]  iter_limit_r;
  logic [31:0] min_step_r;
  logic q_valid, q_ready, busy;
  tdse_pkg::item_t in_item, q_item;

  assign in_item = '{residual: in_ch.residual, last: in_ch.last_residual};
  assign cfg_ch.ready = 1'b1;

  // hold configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dof_r <= tdse_pkg::DofReset;
      iter_limit_r <= tdse_pkg::IterLimitReset;
      min_step_r <= tdse_pkg::MinStepReset;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        tdse_pkg::CfgDof: dof_r <= cfg_ch.data[15:0];
        tdse_pkg::CfgIterLimit: iter_limit_r <= cfg_ch.data[7:0];
        tdse_pkg::CfgMinStep: min_step_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  tdse_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_item(in_item), .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
  );

  tdse_back #(.MaxResiduals(MaxResiduals)) u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_ready(q_ready),
    .q_item(q_item), .dof(dof_r), .iter_limit(iter_limit_r), .min_step(min_step_r),
    .res_valid(out_ch.valid), .res_ready(out_ch.ready),
    .res_sigma(out_ch.scale_sigma), .res_iters(out_ch.iterations_used), .busy(busy)
  );

  // no result while nothing was queued or worked on
  a_out_needs_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(busy))
    else $error("result without work");
  // iterations never exceed the limit
  a_iter_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.iterations_used <= iter_limit_r))
    else $error("iteration count above limit");
endmodule
